@@ design/ipv4p_pkg.sv @@
// Shared types and constants for the dotted IPv4 text parser.
// No dependencies; used by every other file of the block.
`timescale 1ns / 1ps

package ipv4p_pkg;

    // Default limit on characters consumed by one string
    localparam int MAX_CHARS_DEF = 255;

    // One character transfer on the input channel
    typedef struct packed {
        logic [7:0] ch;
        logic       first;
    } t_in_item;

    // One result transfer on the output channel
    typedef struct packed {
        logic [31:0] address;
        logic        status;
        logic [7:0]  consumed;
    } t_out_item;

    // Radix of the part being accumulated
    typedef enum logic [1:0] {
        BASE_8,
        BASE_10,
        BASE_16
    } t_base;

    localparam logic STATUS_OK      = 1'b0;
    localparam logic STATUS_INVALID = 1'b1;

endpackage

@@ design/ipv4_dotted_text_parser_top.sv @@
// Dotted IPv4 text parser, top level: input register, mode register, parse core.
// Depends on ipv4p_pkg and ipv4p_core.
// The terminating character passes through the input register, then the result register.
// Throughput: one character per cycle unless the output stalls; the core updates state on each accepted character.
// Output stall holds the result register and, once the input register is full, the input.
// Reset (synchronous, active low): parse idle, strict mode off, both channels empty.
`timescale 1ns / 1ps

module ipv4_dotted_text_parser_top #(
    parameter int MAX_CHARS = ipv4p_pkg::MAX_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  ipv4p_pkg::t_in_item   i_in_data,
    output logic                  o_in_stall,
    output logic                  o_out_valid,
    output ipv4p_pkg::t_out_item  o_out_data,
    input  logic                  i_out_stall,
    input  logic                  i_cfg_valid,
    input  logic                  i_cfg_data,
    output logic                  o_cfg_ready
);

    logic                 r_in_valid;
    ipv4p_pkg::t_in_item  r_in;
    logic                 r_strict_mode;
    logic                 w_hold;

    assign o_in_stall  = r_in_valid && w_hold;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_strict_mode <= 1'b0;
        end else begin
            if (!o_in_stall) begin
                r_in_valid <= i_in_valid;
                r_in       <= i_in_data;
            end
            if (i_cfg_valid && o_cfg_ready)
                r_strict_mode <= i_cfg_data;
        end
    end

    ipv4p_core #(
        .MAX_CHARS (MAX_CHARS)
    ) u_core (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (r_in_valid),
        .i_item        (r_in),
        .i_strict_mode (r_strict_mode),
        .i_out_stall   (i_out_stall),
        .o_hold        (w_hold),
        .o_out_valid   (o_out_valid),
        .o_out_data    (o_out_data)
    );

endmodule

@@ design/ipv4p_accum.sv @@
// Part accumulator: value * radix + digit, with 32-bit overflow flag.
// Depends on ipv4p_pkg for the radix type.
`timescale 1ns / 1ps

module ipv4p_accum (
    input  logic [31:0]         i_value,
    input  ipv4p_pkg::t_base    i_base,
    input  logic [3:0]          i_digit,
    output logic [31:0]         o_value,
    output logic                o_ovf
);

    logic [35:0] w_ext;
    logic [35:0] w_prod;
    logic [35:0] w_sum;

    assign w_ext = {4'b0000, i_value};

    always_comb begin
        case (i_base)
            ipv4p_pkg::BASE_8:  w_prod = w_ext << 3;
            ipv4p_pkg::BASE_10: w_prod = (w_ext << 3) + (w_ext << 1);
            ipv4p_pkg::BASE_16: w_prod = w_ext << 4;
            default:            w_prod = w_ext << 3;
        endcase
    end

    assign w_sum   = w_prod + {32'd0, i_digit};
    assign o_value = w_sum[31:0];
    assign o_ovf   = |w_sum[35:32];

endmodule

@@ design/ipv4p_pack.sv @@
// Address packer: joins one to four parts with the per-form width checks.
// Depends on ipv4p_pkg for the result type and status codes.
`timescale 1ns / 1ps

module ipv4p_pack #(
    parameter int MAX_CHARS = ipv4p_pkg::MAX_CHARS_DEF
) (
    input  logic [2:0]                           i_nparts,
    input  logic [$clog2(MAX_CHARS + 2)-1:0]     i_cons,
    input  logic                                 i_strict_mode,
    input  logic [31:0]                          i_p0,
    input  logic [31:0]                          i_p1,
    input  logic [31:0]                          i_p2,
    input  logic [31:0]                          i_last,
    output ipv4p_pkg::t_out_item                 o_result
);

    localparam int CW = $clog2(MAX_CHARS + 2);
    localparam logic [31:0] LIM_8  = 32'h0000_00FF;
    localparam logic [31:0] LIM_16 = 32'h0000_FFFF;
    localparam logic [31:0] LIM_24 = 32'h00FF_FFFF;

    logic        w_ok;
    logic [31:0] w_addr;

    always_comb begin
        w_ok   = 1'b0;
        w_addr = '0;
        case (i_nparts)
            3'd1: begin
                w_ok   = 1'b1;
                w_addr = i_last;
            end
            3'd2: begin
                w_ok   = (i_p0 <= LIM_8) && (i_last <= LIM_24);
                w_addr = {i_p0[7:0], i_last[23:0]};
            end
            3'd3: begin
                w_ok   = (i_p0 <= LIM_8) && (i_p1 <= LIM_8) && (i_last <= LIM_16);
                w_addr = {i_p0[7:0], i_p1[7:0], i_last[15:0]};
            end
            3'd4: begin
                w_ok   = (i_p0 <= LIM_8) && (i_p1 <= LIM_8) && (i_p2 <= LIM_8)
                         && (i_last <= LIM_8);
                w_addr = {i_p0[7:0], i_p1[7:0], i_p2[7:0], i_last[7:0]};
            end
            default: begin
                w_ok   = 1'b0;
                w_addr = '0;
            end
        endcase
        if (i_cons > CW'(MAX_CHARS))
            w_ok = 1'b0;
        if (i_strict_mode && (i_nparts != 3'd4))
            w_ok = 1'b0;
    end

    always_comb begin
        if (w_ok) begin
            o_result.address  = w_addr;
            o_result.status   = ipv4p_pkg::STATUS_OK;
            o_result.consumed = 8'(i_cons);
        end else begin
            o_result.address  = '0;
            o_result.status   = ipv4p_pkg::STATUS_INVALID;
            o_result.consumed = '0;
        end
    end

endmodule

@@ design/ipv4p_core.sv @@
// Parse state machine: one character per cycle while the result is not stalled, part storage, result register.
// Depends on ipv4p_pkg, ipv4p_accum and ipv4p_pack.
`timescale 1ns / 1ps

module ipv4p_core #(
    parameter int MAX_CHARS = ipv4p_pkg::MAX_CHARS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    input  ipv4p_pkg::t_in_item   i_item,
    input  logic                  i_strict_mode,
    input  logic                  i_out_stall,
    output logic                  o_hold,
    output logic                  o_out_valid,
    output ipv4p_pkg::t_out_item  o_out_data
);

    localparam int CW = $clog2(MAX_CHARS + 2);

    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_7   = 8'h37;
    localparam logic [7:0] CH_9   = 8'h39;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_LX  = 8'h78;
    localparam logic [7:0] CH_UX  = 8'h58;
    localparam logic [7:0] CH_LA  = 8'h61;
    localparam logic [7:0] CH_LF  = 8'h66;
    localparam logic [7:0] CH_UA  = 8'h41;
    localparam logic [7:0] CH_UF  = 8'h46;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_START,
        PH_ZERO,
        PH_DEC,
        PH_OCT,
        PH_HEX,
        PH_DONE
    } t_phase;

    // {is hex digit, value}
    function automatic logic [4:0] hex_val(input logic [7:0] c);
        logic [4:0] v;
        v = '0;
        if (c >= CH_0 && c <= CH_9)
            v = {1'b1, c[3:0]};
        else if ((c >= CH_LA && c <= CH_LF) || (c >= CH_UA && c <= CH_UF))
            v = {1'b1, c[3:0] + 4'd9};
        return v;
    endfunction

    t_phase                r_phase;
    logic [31:0]           r_pv;
    logic [1:0]            r_cnt;
    logic [CW-1:0]         r_chars;
    logic [31:0]           r_parts [3];
    logic                  r_out_valid;
    ipv4p_pkg::t_out_item  r_out;

    t_phase                n_phase;
    logic [31:0]           n_pv;
    logic [1:0]            n_cnt;
    logic [CW-1:0]         n_chars;
    ipv4p_pkg::t_out_item  n_out;

    logic                  w_hold;
    logic                  w_go;
    logic [7:0]            w_c;
    logic                  w_dig;
    logic                  w_oct;
    logic [4:0]            w_hex;
    t_phase                w_ph;
    logic [31:0]           w_pv;
    logic [1:0]            w_cnt;
    logic [CW-1:0]         w_chars;
    logic [CW-1:0]         w_chars_inc;

    logic                  w_acc_en;
    t_phase                w_acc_phase;
    ipv4p_pkg::t_base      w_base;
    logic [3:0]            w_digit;
    logic [31:0]           w_acc_in;
    logic [31:0]           w_acc_out;
    logic                  w_acc_ovf;
    logic                  w_dot_en;
    logic                  w_fin_en;
    logic                  w_fail_en;

    logic                  w_parts_we;
    logic                  w_finish;
    logic                  w_fail;
    logic [2:0]            w_nparts;
    logic [CW-1:0]         w_cons;
    ipv4p_pkg::t_out_item  w_packed;

    assign w_hold = r_out_valid && i_out_stall;
    assign w_go   = i_valid && !w_hold;
    assign o_hold = w_hold;

    assign w_c         = i_item.ch;
    assign w_dig       = (w_c >= CH_0) && (w_c <= CH_9);
    assign w_oct       = (w_c >= CH_0) && (w_c <= CH_7);
    assign w_hex       = hex_val(w_c);
    // first mark restarts the parse from any phase
    assign w_ph        = i_item.first ? PH_START : r_phase;
    assign w_pv        = i_item.first ? 32'd0 : r_pv;
    assign w_cnt       = i_item.first ? 2'd0 : r_cnt;
    assign w_chars     = i_item.first ? '0 : r_chars;
    assign w_chars_inc = w_chars + 1'b1;
    assign w_acc_in    = (w_ph == PH_START) ? 32'd0 : w_pv;

    // character classification per phase
    always_comb begin
        w_acc_en    = 1'b0;
        w_acc_phase = w_ph;
        w_base      = ipv4p_pkg::BASE_10;
        w_digit     = w_c[3:0];
        w_dot_en    = 1'b0;
        w_fin_en    = 1'b0;
        w_fail_en   = 1'b0;
        case (w_ph)
            PH_START: begin
                if (!w_dig) begin
                    w_fail_en = 1'b1;
                end else begin
                    w_acc_en    = 1'b1;
                    w_acc_phase = (w_c == CH_0 && !i_strict_mode) ? PH_ZERO : PH_DEC;
                end
            end
            PH_ZERO: begin
                if (w_c == CH_LX || w_c == CH_UX) begin
                    w_acc_en    = 1'b1;
                    w_acc_phase = PH_HEX;
                    w_base      = ipv4p_pkg::BASE_16;
                    w_digit     = 4'd0;
                end else if (w_oct) begin
                    w_acc_en    = 1'b1;
                    w_acc_phase = PH_OCT;
                    w_base      = ipv4p_pkg::BASE_8;
                end else if (w_dig) begin
                    w_acc_en    = 1'b1;
                    w_acc_phase = PH_DEC;
                end else if (w_c == CH_DOT) begin
                    w_dot_en = 1'b1;
                end else begin
                    w_fin_en = 1'b1;
                end
            end
            PH_DEC: begin
                if (w_dig)
                    w_acc_en = 1'b1;
                else if (w_c == CH_DOT)
                    w_dot_en = 1'b1;
                else
                    w_fin_en = 1'b1;
            end
            PH_OCT: begin
                w_base = ipv4p_pkg::BASE_8;
                if (w_oct)
                    w_acc_en = 1'b1;
                else if (w_c == CH_DOT)
                    w_dot_en = 1'b1;
                else
                    w_fin_en = 1'b1;
            end
            PH_HEX: begin
                w_base  = ipv4p_pkg::BASE_16;
                w_digit = w_hex[3:0];
                if (w_hex[4])
                    w_acc_en = 1'b1;
                else if (w_c == CH_DOT)
                    w_dot_en = 1'b1;
                else
                    w_fin_en = 1'b1;
            end
            default: begin
                w_acc_en = 1'b0;
            end
        endcase
    end

    ipv4p_accum u_accum (
        .i_value (w_acc_in),
        .i_base  (w_base),
        .i_digit (w_digit),
        .o_value (w_acc_out),
        .o_ovf   (w_acc_ovf)
    );

    // next state and result selection
    always_comb begin
        n_phase    = w_ph;
        n_pv       = w_pv;
        n_cnt      = w_cnt;
        n_chars    = w_chars;
        w_parts_we = 1'b0;
        w_finish   = 1'b0;
        w_fail     = w_fail_en;
        w_nparts   = {1'b0, w_cnt} + 3'd1;
        w_cons     = w_chars;
        if (w_acc_en) begin
            if (w_acc_ovf) begin
                w_fail = 1'b1;
            end else begin
                n_pv    = w_acc_out;
                n_phase = w_acc_phase;
                n_chars = w_chars_inc;
                if (w_chars_inc > CW'(MAX_CHARS))
                    w_fail = 1'b1;
            end
        end
        if (w_dot_en) begin
            if (w_cnt == 2'd3) begin
                // dot after the fourth part closes the string, dot counted
                w_finish = 1'b1;
                w_nparts = 3'd4;
                w_cons   = w_chars_inc;
            end else begin
                w_parts_we = 1'b1;
                n_cnt      = w_cnt + 2'd1;
                n_pv       = 32'd0;
                n_phase    = PH_START;
                n_chars    = w_chars_inc;
                if (w_chars_inc > CW'(MAX_CHARS))
                    w_fail = 1'b1;
            end
        end
        if (w_fin_en)
            w_finish = 1'b1;

        n_out = w_packed;
        if (w_fail) begin
            n_out.address  = '0;
            n_out.status   = ipv4p_pkg::STATUS_INVALID;
            n_out.consumed = '0;
        end
        if (w_fail || w_finish)
            n_phase = PH_DONE;
    end

    ipv4p_pack #(
        .MAX_CHARS (MAX_CHARS)
    ) u_pack (
        .i_nparts      (w_nparts),
        .i_cons        (w_cons),
        .i_strict_mode (i_strict_mode),
        .i_p0          (r_parts[0]),
        .i_p1          (r_parts[1]),
        .i_p2          (r_parts[2]),
        .i_last        (w_pv),
        .o_result      (w_packed)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_pv        <= '0;
            r_cnt       <= '0;
            r_chars     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_go) begin
                r_phase <= n_phase;
                r_pv    <= n_pv;
                r_cnt   <= n_cnt;
                r_chars <= n_chars;
                if (w_parts_we)
                    r_parts[w_cnt] <= w_pv;
                if (w_fail || w_finish)
                    r_out <= n_out;
            end
            if (!w_hold)
                r_out_valid <= w_go && (w_fail || w_finish);
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

@@ design/ipv4p_checker.sv @@
// Port-level checks for the dotted IPv4 text parser, bound to the top level.
// Depends on ipv4p_pkg and ipv4_dotted_text_parser_top.
`timescale 1ns / 1ps

module ipv4p_checker (
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_stall,
    input logic                  o_out_valid,
    input logic                  i_out_stall,
    input ipv4p_pkg::t_out_item  o_out_data
);

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed while stalled");

    // invalid results carry zero address and zero count
    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_data.status == ipv4p_pkg::STATUS_INVALID)
        |-> (o_out_data.address == 32'd0) && (o_out_data.consumed == 8'd0))
        else $error("invalid result with nonzero fields");

    // input is stalled only behind a blocked result
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without output backpressure");

    // a fresh result follows an input transfer, through the input and result registers
    a_result_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result without a matching input transfer");

endmodule

bind ipv4_dotted_text_parser_top ipv4p_checker u_ipv4p_checker (.*);

@@ tb/sv/ipv4_dotted_text_parser_top_tb.sv @@
// Self-checking testbench for ipv4_dotted_text_parser_top: random and directed address strings.
// Depends on ipv4p_pkg and the parser RTL; holds its own parse predictor in a small class.
`timescale 1ns / 1ps

module ipv4_dotted_text_parser_top_tb;

    localparam int unsigned CYCLE_LIMIT = 300000;
    localparam int unsigned MAX_CHARS = ipv4p_pkg::MAX_CHARS_DEF;

    typedef enum logic [2:0] {
        SCAN_IDLE,
        SCAN_START,
        SCAN_ZERO,
        SCAN_DEC,
        SCAN_OCT,
        SCAN_HEX,
        SCAN_DONE
    } t_scan;

    // Predicts the address result of each string and checks what the block returns
    class ipv4_parse_board;
        bit                   strict;
        t_scan                scan;
        bit [31:0]            part_val;
        bit [31:0]            parts [3];
        int unsigned          part_cnt;
        int unsigned          char_cnt;
        ipv4p_pkg::t_out_item pending_results [$];
        int unsigned          errors;

        function new();
            strict   = 1'b0;
            scan     = SCAN_IDLE;
            part_val = '0;
            part_cnt = 0;
            char_cnt = 0;
            errors   = 0;
        endfunction

        function int unsigned pending();
            return pending_results.size();
        endfunction

        function void post(bit [31:0] addr, logic st, int unsigned cons);
            ipv4p_pkg::t_out_item r;
            r.address  = addr;
            r.status   = st;
            r.consumed = cons[7:0];
            pending_results.push_back(r);
            scan = SCAN_DONE;
        endfunction

        function void reject();
            post('0, ipv4p_pkg::STATUS_INVALID, 0);
        endfunction

        // last part is part_val; n counts all parts
        function void close_address(int unsigned n, int unsigned cons);
            bit [31:0] addr;
            bit        bad;
            addr = '0;
            bad  = (cons > MAX_CHARS) || (strict && n != 4);
            case (n)
                1: addr = part_val;
                2: begin
                    bad  = bad || parts[0] > 255 || part_val > 32'h00FF_FFFF;
                    addr = {parts[0][7:0], part_val[23:0]};
                end
                3: begin
                    bad  = bad || parts[0] > 255 || parts[1] > 255 || part_val > 32'h0000_FFFF;
                    addr = {parts[0][7:0], parts[1][7:0], part_val[15:0]};
                end
                4: begin
                    bad  = bad || parts[0] > 255 || parts[1] > 255 || parts[2] > 255
                           || part_val > 32'h0000_00FF;
                    addr = {parts[0][7:0], parts[1][7:0], parts[2][7:0], part_val[7:0]};
                end
                default: bad = 1'b1;
            endcase
            if (bad) reject();
            else post(addr, ipv4p_pkg::STATUS_OK, cons);
        endfunction

        function void end_part_at_dot();
            if (part_cnt >= 3) begin
                // dot after the fourth part is counted
                char_cnt++;
                close_address(4, char_cnt);
                return;
            end
            parts[part_cnt] = part_val;
            part_cnt++;
            part_val = '0;
            scan     = SCAN_START;
            char_cnt++;
            if (char_cnt > MAX_CHARS) reject();
        endfunction

        function void add_digit(ipv4p_pkg::t_base b, int unsigned digit);
            bit [63:0]   nv;
            int unsigned radix;
            case (b)
                ipv4p_pkg::BASE_8:  radix = 8;
                ipv4p_pkg::BASE_16: radix = 16;
                default:            radix = 10;
            endcase
            nv = {32'd0, part_val} * radix + digit;
            if (nv > 64'h0000_0000_FFFF_FFFF) begin
                reject();
                return;
            end
            part_val = nv[31:0];
            char_cnt++;
            if (char_cnt > MAX_CHARS) reject();
        endfunction

        function int hex_value(bit [7:0] c);
            if (c >= "0" && c <= "9") return c - "0";
            if (c >= "a" && c <= "f") return c - "a" + 10;
            if (c >= "A" && c <= "F") return c - "A" + 10;
            return -1;
        endfunction

        function void note_char(ipv4p_pkg::t_in_item it);
            bit [7:0] c;
            bit       digit_ch;
            int       hv;
            c        = it.ch;
            digit_ch = (c >= "0" && c <= "9");
            if (it.first) begin
                scan     = SCAN_START;
                part_val = '0;
                part_cnt = 0;
                char_cnt = 0;
            end
            case (scan)
                SCAN_START: begin
                    if (!digit_ch) begin
                        reject();
                    end else if (c == "0" && !strict) begin
                        part_val = '0;
                        scan = SCAN_ZERO;
                        add_digit(ipv4p_pkg::BASE_10, 0);
                    end else begin
                        part_val = '0;
                        scan = SCAN_DEC;
                        add_digit(ipv4p_pkg::BASE_10, c - "0");
                    end
                end
                SCAN_ZERO: begin
                    if (c == "x" || c == "X") begin
                        scan = SCAN_HEX;
                        add_digit(ipv4p_pkg::BASE_16, 0);
                    end else if (c >= "0" && c <= "7") begin
                        scan = SCAN_OCT;
                        add_digit(ipv4p_pkg::BASE_8, c - "0");
                    end else if (digit_ch) begin
                        scan = SCAN_DEC;
                        add_digit(ipv4p_pkg::BASE_10, c - "0");
                    end else if (c == ".") begin
                        end_part_at_dot();
                    end else begin
                        close_address(part_cnt + 1, char_cnt);
                    end
                end
                SCAN_DEC: begin
                    if (digit_ch) add_digit(ipv4p_pkg::BASE_10, c - "0");
                    else if (c == ".") end_part_at_dot();
                    else close_address(part_cnt + 1, char_cnt);
                end
                SCAN_OCT: begin
                    if (c >= "0" && c <= "7") add_digit(ipv4p_pkg::BASE_8, c - "0");
                    else if (c == ".") end_part_at_dot();
                    else close_address(part_cnt + 1, char_cnt);
                end
                SCAN_HEX: begin
                    hv = hex_value(c);
                    if (hv >= 0) add_digit(ipv4p_pkg::BASE_16, hv);
                    else if (c == ".") end_part_at_dot();
                    else close_address(part_cnt + 1, char_cnt);
                end
                default: ;
            endcase
        endfunction

        function void check_result(ipv4p_pkg::t_out_item got);
            ipv4p_pkg::t_out_item want;
            if (pending_results.size() == 0) begin
                $error("unexpected result: address %h status %0b consumed %0d",
                       got.address, got.status, got.consumed);
                errors++;
                return;
            end
            want = pending_results.pop_front();
            if (got.address !== want.address) begin
                $error("address: expected %h, actual %h", want.address, got.address);
                errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0b, actual %0b", want.status, got.status);
                errors++;
            end
            if (got.consumed !== want.consumed) begin
                $error("consumed: expected %0d, actual %0d", want.consumed, got.consumed);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    ipv4p_pkg::t_in_item  i_in_data;
    logic                 o_in_stall;
    logic                 o_out_valid;
    ipv4p_pkg::t_out_item o_out_data;
    logic                 i_out_stall = 1'b0;
    logic                 i_cfg_valid;
    logic                 i_cfg_data;
    logic                 o_cfg_ready;

    ipv4_parse_board board;
    bit              quiet = 1'b0;
    int unsigned     gap_pct = 0;
    int unsigned     stall_pct = 0;
    int unsigned     stall_left = 0;
    int unsigned     cycle_count = 0;
    int unsigned     chars_sent = 0;

    ipv4_dotted_text_parser_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("ipv4_dotted_text_parser_top_tb: done, errors");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) board.check_result(o_out_data);
    end

    // Output backpressure in random bursts; the rate drifts between calm and busy
    always @(negedge i_clk) begin
        if (cycle_count % 150 == 0) begin
            case ($urandom_range(0, 2))
                0: stall_pct = 0;
                1: stall_pct = 8;
                default: stall_pct = 30;
            endcase
        end
        if (quiet || !i_rst_n) begin
            i_out_stall = 1'b0;
            stall_left  = 0;
        end else if (stall_left != 0) begin
            stall_left--;
            i_out_stall = 1'b1;
        end else if ($urandom_range(0, 99) < stall_pct) begin
            stall_left  = $urandom_range(0, 9);
            i_out_stall = 1'b1;
        end else begin
            i_out_stall = 1'b0;
        end
    end

    function automatic void push_text(ref bit [7:0] s[$], input string t, input bit mix);
        bit [7:0] c;
        for (int k = 0; k < t.len(); k++) begin
            c = t[k];
            if (mix && c >= "a" && c <= "f" && $urandom_range(0, 1)) c = c - 8'd32;
            s.push_back(c);
        end
    endfunction

    function automatic bit is_grammar(bit [7:0] c);
        return (c >= "0" && c <= "9") || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")
               || c == "x" || c == "X" || c == ".";
    endfunction

    // One part of an address; maxv is the widest value that fits its position
    function automatic void add_part(ref bit [7:0] s[$], input bit strict_on,
                                     input int unsigned maxv);
        int unsigned v;
        v = 0;
        case ($urandom_range(0, 9))
            6: v = (maxv == 32'hFFFF_FFFF) ? maxv : maxv + $urandom_range(0, 1);
            7: v = $urandom;
            8: v = 0;
            9: begin
                if (!strict_on && $urandom_range(0, 1)) begin
                    push_text(s, $sformatf("0x1%h", $urandom), 1'b1);
                end else begin
                    // 429496729 plus one more digit lands just under, at or just past 2^32
                    push_text(s, $sformatf("%0d%0d", 32'd429496729 + $urandom_range(0, 3),
                                           $urandom_range(0, 9)), 1'b0);
                end
                return;
            end
            default: v = $urandom_range(0, maxv);
        endcase
        if (strict_on) begin
            push_text(s, $sformatf("%0d", v), 1'b0);
            return;
        end
        case ($urandom_range(0, 5))
            3: push_text(s, $sformatf("0%0o", v), 1'b0);
            4: begin
                s.push_back("0");
                s.push_back($urandom_range(0, 1) ? "x" : "X");
                // bare prefix reads as zero
                if (v != 0 || $urandom_range(0, 1)) push_text(s, $sformatf("%0h", v), 1'b1);
            end
            5: push_text(s, $sformatf("0%0d%0d", $urandom_range(8, 9), $urandom_range(0, 99)),
                         1'b0);
            default: push_text(s, $sformatf("%0d", v), 1'b0);
        endcase
    endfunction

    function automatic void build_addr(ref bit [7:0] s[$], input bit strict_on);
        int unsigned n;
        int unsigned maxv;
        bit [7:0]    c;
        s.delete();
        n = strict_on ? 4 : $urandom_range(1, 4);
        if ($urandom_range(0, 9) == 0) n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) begin
            if (i > 0) s.push_back(".");
            if (i < n - 1) begin
                maxv = 255;
            end else begin
                case (n)
                    1: maxv = 32'hFFFF_FFFF;
                    2: maxv = 32'h00FF_FFFF;
                    3: maxv = 32'h0000_FFFF;
                    default: maxv = 255;
                endcase
            end
            add_part(s, strict_on, maxv);
        end
        case ($urandom_range(0, 9))
            5, 6: begin
                do c = 8'($urandom_range(0, 255)); while (is_grammar(c));
                s.push_back(c);
            end
            7: s.push_back(".");
            8: ;  // left open, the next first mark restarts
            9: begin
                s.push_back(8'h00);
                repeat ($urandom_range(1, 4)) s.push_back(8'($urandom_range(0, 255)));
            end
            default: s.push_back(8'h00);
        endcase
    endfunction

    // Called at a falling edge; returns at the falling edge after the transfer
    task automatic send_char(input bit [7:0] c, input bit f);
        ipv4p_pkg::t_in_item it;
        it.ch    = c;
        it.first = f;
        if ($urandom_range(0, 99) < gap_pct) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_data  = it;
        do @(posedge i_clk); while (o_in_stall);
        board.note_char(it);
        chars_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input bit [7:0] s[$]);
        for (int k = 0; k < s.size(); k++) send_char(s[k], k == 0);
    endtask

    task automatic send_directed(input string t, input bit [7:0] stop);
        bit [7:0] s[$];
        push_text(s, t, 1'b0);
        s.push_back(stop);
        send_text(s);
    endtask

    // Park the input and let the block empty; the tail covers strings still open
    task automatic wait_idle();
        i_in_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (6) @(negedge i_clk);
    endtask

    task automatic set_mode(input bit m);
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        do @(posedge i_clk); while (!o_cfg_ready);
        board.strict = m;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int unsigned n_items, input bit with_long);
        bit [7:0]    s[$];
        int unsigned start;
        int unsigned sel;
        int unsigned pos;
        bit          long_done;
        bit          paused;
        start     = chars_sent;
        long_done = 1'b0;
        paused    = 1'b0;
        while (chars_sent - start < n_items) begin
            gap_pct = (quiet || $urandom_range(0, 2) == 0) ? 0 : 30;
            sel = $urandom_range(0, 99);
            if (with_long && !long_done && chars_sent - start > n_items / 2) begin
                // about MAX_CHARS consumed, just under or just over the limit
                s.delete();
                push_text(s, "1.2.3.", 1'b0);
                repeat ($urandom_range(243, 253)) s.push_back("0");
                s.push_back("4");
                s.push_back(8'h00);
                send_text(s);
                long_done = 1'b1;
            end else if (sel < 10) begin
                repeat ($urandom_range(1, 6))
                    send_char(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
            end else begin
                build_addr(s, board.strict);
                if (sel < 25) begin
                    pos = $urandom_range(0, s.size() - 1);
                    case ($urandom_range(0, 3))
                        0: s[pos] = 8'($urandom_range(0, 255));
                        1: s.insert(pos, ".");
                        2: if (s.size() > 1) s.delete(pos);
                        default: while (s.size() > pos + 1) s.pop_back();
                    endcase
                end
                send_text(s);
            end
            if (with_long && !paused && chars_sent - start > n_items / 4) begin
                wait_idle();
                paused = 1'b1;
            end
        end
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_data   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_data  = 1'b0;
        board = new();
        repeat (10) @(negedge i_clk);
        i_rst_n = 1'b1;

        set_mode(1'b0);
        send_char("A", 1'b0);          // no first mark while idle: dropped
        send_directed("0xFf", 8'h00);
        send_directed("0x", 8'h00);    // hex prefix with no digits
        send_directed("017", "8");     // 8 stops an octal part
        send_directed("09", " ");      // 0 then 9 stays decimal
        send_directed("0", ";");
        send_directed("", ".");        // part cannot start with a dot
        send_directed("1.", ".");
        send_directed("256.1", 8'hFF); // top byte too wide

        wait_idle();
        set_mode(1'b1);
        run_random(300, 1'b0);
        wait_idle();
        set_mode(1'b0);
        run_random(420, 1'b1);
        wait_idle();
        set_mode(1'b1);
        run_random(200, 1'b0);
        wait_idle();
        set_mode(1'b0);
        quiet = 1'b1;
        run_random(230, 1'b0);

        i_in_valid = 1'b0;
        while (board.pending() != 0) @(negedge i_clk);
        repeat (10) @(posedge i_clk);
        if (board.errors == 0) begin
            $display("ipv4_dotted_text_parser_top_tb: done, clean");
        end else begin
            $display("ipv4_dotted_text_parser_top_tb: done, errors");
        end
        $finish;
    end

endmodule

@@ sim.f @@
design/ipv4p_pkg.sv
design/ipv4p_accum.sv
design/ipv4p_pack.sv
design/ipv4p_core.sv
design/ipv4_dotted_text_parser_top.sv
design/ipv4p_checker.sv
tb/sv/ipv4_dotted_text_parser_top_tb.sv
